/* design/chist_pkg.sv */
package chist_pkg;

    localparam int PIX_W     = 8;
    localparam int BIN_SHIFT = 5;
    localparam int BIN_W     = PIX_W - BIN_SHIFT;
    localparam int OUT_BINS  = 8;
    localparam int COUNT_W   = 11;
    localparam int TOTAL_W   = 21;
    localparam int WIDTH_W   = 11;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [PIX_W-1:0]   t_pixel;
    typedef logic [BIN_W-1:0]   t_bin;

    // per-pixel control handed from the row tracker to the update stage
    typedef struct packed {
        logic first_row;
    } t_pix_flags;

endpackage

/* design/chist_line_mem.sv */
module chist_line_mem
    import chist_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 168
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // read returns the old word when the same entry is written in this cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/chist_front.sv */
module chist_front
    import chist_pkg::*;
#(
    parameter int NUM_BINS  = 8,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  t_pixel                            i_pixel_value,
    input  logic                              i_frame_start,
    input  logic [WIDTH_W-1:0]                i_image_width,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output logic [NUM_BINS-1:0][COUNT_W-1:0]  o_counts,
    output t_pix_flags                        o_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    logic [COL_W-1:0]                 r_col;
    logic                             r_first_row;
    logic [NUM_BINS-1:0][COUNT_W-1:0] r_counts;

    logic [NUM_BINS-1:0][COUNT_W-1:0] base_counts;
    logic [CMP_W-1:0]                 width_eff;
    logic [CMP_W-1:0]                 col_next;
    logic                             row_end;
    t_bin                             bin;

    assign bin = i_pixel_value[PIX_W-1:BIN_SHIFT];

    always_comb begin
        width_eff = CMP_W'(i_image_width);
        if (i_image_width == '0) begin
            width_eff = CMP_W'(1);
        end else if (CMP_W'(i_image_width) > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
    end

    assign o_col             = i_frame_start ? '0 : r_col;
    assign o_flags.first_row = i_frame_start | r_first_row;
    assign base_counts       = i_frame_start ? '0 : r_counts;

    always_comb begin
        for (int b = 0; b < NUM_BINS; b++) begin
            o_counts[b] = base_counts[b];
            if (bin == BIN_W'(b) && base_counts[b] != COUNT_MAX) begin
                o_counts[b] = base_counts[b] + COUNT_W'(1);
            end
        end
    end

    assign col_next = CMP_W'(o_col) + CMP_W'(1);
    assign row_end  = col_next >= width_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_first_row <= 1'b1;
            r_counts    <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col       <= '0;
                r_first_row <= 1'b0;
                r_counts    <= '0;
            end else begin
                r_col       <= col_next[COL_W-1:0];
                r_first_row <= o_flags.first_row;
                r_counts    <= o_counts;
            end
        end
    end

endmodule

/* design/chist_update.sv */
module chist_update
    import chist_pkg::*;
#(
    parameter int NUM_BINS  = 8,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_col,
    input  logic [NUM_BINS-1:0][COUNT_W-1:0]  i_counts,
    input  t_pix_flags                        i_flags,
    input  logic [NUM_BINS-1:0][TOTAL_W-1:0]  i_rd_data,
    input  logic                              i_out_stall,
    output logic                              o_in_stall,
    output logic                              o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_wr_addr,
    output logic [NUM_BINS-1:0][TOTAL_W-1:0]  o_wr_data,
    output logic                              o_out_valid,
    output logic [NUM_BINS-1:0][TOTAL_W-1:0]  o_totals
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                             r_s1_valid;
    logic [COL_W-1:0]                 r_s1_col;
    logic [NUM_BINS-1:0][COUNT_W-1:0] r_s1_counts;
    logic                             r_s1_first;
    logic                             r_s1_fwd;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] r_fwd_data;
    logic                             r_out_valid;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] r_out_data;

    logic                             s1_adv;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] above;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] totals;
    logic [TOTAL_W:0]                 sum;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;

    always_comb begin
        sum = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            if (r_s1_first) begin
                above[b] = '0;
            end else if (r_s1_fwd) begin
                above[b] = r_fwd_data[b];
            end else begin
                above[b] = i_rd_data[b];
            end
            sum       = {1'b0, above[b]} + (TOTAL_W + 1)'(r_s1_counts[b]);
            totals[b] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
    end

    assign o_wr_en   = s1_adv;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = totals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the line memory read misses a write-back to the same column in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col    <= i_col;
            r_s1_counts <= i_counts;
            r_s1_first  <= i_flags.first_row;
            r_s1_fwd    <= s1_adv && (r_s1_col == i_col);
            r_fwd_data  <= totals;
        end
        if (s1_adv) begin
            r_out_data <= totals;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_totals    = r_out_data;

    a_wr_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> r_out_valid)
        else $error("write-back without a result in the output register");

    a_held_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_col))
        else $error("held update stage lost its pixel");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_accept) && r_s1_fwd |-> $past(o_wr_en) && $past(o_wr_addr) == r_s1_col)
        else $error("forwarded data does not come from a write to the same column");

endmodule

/* design/color_integral_histogram.sv */
// Integral histogram of one 8-bit color plane, one pixel per transaction in raster order.
// Each pixel falls into bin pixel_value/32; bins at or above NUM_BINS count nowhere and
// their outputs read zero. For every pixel the block returns, per bin, the number of
// pixels of that bin in the rectangle from the frame origin to this pixel, saturating at
// 2^21-1. frame_start on a pixel restarts the frame at row 0, column 0. The user must
// write image_width only while the block is idle; the block does not enforce it. 0 acts
// as 1 and values above MAX_WIDTH act as MAX_WIDTH. Throughput is one pixel per clock
// while the consumer does not stall: the previous row's totals sit in a single line
// memory, one word per column holding all bins, read when a pixel is taken; when the
// update stage advances, the pixel's totals are written back and taken by the output
// register, with a bypass when two pixels in a row hit the same column (one-pixel rows).
// The input stalls only while the update stage holds a pixel behind a result the consumer
// has not taken yet. No clearing pass after reset is needed: the first row ignores reads.
module color_integral_histogram
    import chist_pkg::*;
#(
    parameter int NUM_BINS  = 8,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [WIDTH_W-1:0]  i_cfg_wr_data,
    // pixel channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [PIX_W-1:0]    i_pixel_value,
    input  logic                i_frame_start,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TOTAL_W-1:0]  o_bin0_total,
    output logic [TOTAL_W-1:0]  o_bin1_total,
    output logic [TOTAL_W-1:0]  o_bin2_total,
    output logic [TOTAL_W-1:0]  o_bin3_total,
    output logic [TOTAL_W-1:0]  o_bin4_total,
    output logic [TOTAL_W-1:0]  o_bin5_total,
    output logic [TOTAL_W-1:0]  o_bin6_total,
    output logic [TOTAL_W-1:0]  o_bin7_total
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [WIDTH_W-1:0]               r_image_width;
    logic                             accept;
    logic [COL_W-1:0]                 col;
    logic [NUM_BINS-1:0][COUNT_W-1:0] counts;
    t_pix_flags                       flags;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] rd_data;
    logic                             wr_en;
    logic [COL_W-1:0]                 wr_addr;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] wr_data;
    logic [NUM_BINS-1:0][TOTAL_W-1:0] totals;
    t_total                           bin_total [OUT_BINS];

    // configuration register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_image_width <= i_cfg_wr_data;
        end
    end

    // a pixel transaction completes when valid meets no stall
    assign accept = i_in_valid && !o_in_stall;

    // column / first-row tracking and running row counts per bin
    chist_front #(
        .NUM_BINS  (NUM_BINS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .i_image_width (r_image_width),
        .o_col         (col),
        .o_counts      (counts),
        .o_flags       (flags)
    );

    // previous row's integral totals, one word per column
    chist_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (NUM_BINS * TOTAL_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // add above + row count, write back, and hold the result for the consumer
    chist_update #(
        .NUM_BINS  (NUM_BINS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_col       (col),
        .i_counts    (counts),
        .i_flags     (flags),
        .i_rd_data   (rd_data),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .o_totals    (totals)
    );

    // unused bins read zero
    for (genvar k = 0; k < OUT_BINS; k++) begin : g_bins
        if (k < NUM_BINS) begin : g_used
            assign bin_total[k] = totals[k];
        end else begin : g_unused
            assign bin_total[k] = '0;
        end
    end

    assign o_bin0_total = bin_total[0];
    assign o_bin1_total = bin_total[1];
    assign o_bin2_total = bin_total[2];
    assign o_bin3_total = bin_total[3];
    assign o_bin4_total = bin_total[4];
    assign o_bin5_total = bin_total[5];
    assign o_bin6_total = bin_total[6];
    assign o_bin7_total = bin_total[7];

endmodule
